// ----- rtl/gedw_pkg.sv -----
package gedw_pkg;

  // Window geometry; the mask register layout fixes a 5x5 window
  localparam int MAX_WINDOW = 5;
  localparam int MAX_RADIUS = (MAX_WINDOW - 1) / 2;
  localparam int RAD_W      = 2;
  localparam int MASK_W     = MAX_WINDOW * MAX_WINDOW;

  // Row counter and frame height limit
  localparam int ROW_W    = 10;
  localparam int DIM_W    = 11;
  localparam int MAX_ROWS = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MASK_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERODE  = 3'd0,
    CFG_RADIUS = 3'd1,
    CFG_MASK   = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } cfg_idx_e;

  // Control handed from the top level to every window cell
  typedef struct packed {
    logic shift;   // take the neighbor's column
    logic adv;     // pipeline advances, register the column result
    logic erode;   // 1: minimum, 0: maximum
  } cell_ctrl_t;

endpackage

// ----- rtl/grayscale_erode_dilate_window_unit.sv -----
// Channel | Direction | Handshake                 | Payload
// input   | in        | in_valid_i / in_ready_o   | pixel_in_i
// output  | out       | out_valid_o / out_ready_i | pixel_out_o, row_end_o, frame_end_o
// config  | in        | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// Sustained rate is one pixel per cycle while the output is not held; a taken pixel
// passes in order through the line-store read register, window shift, column reduction
// in each cell and the final combine into the output register.
// Reset clears counters, configuration and the window; the line store is not
// cleared, so no clearing pass is run and the input is ready right after reset.
// While a result waits on out_ready_i the whole pipe holds and in_ready_o drops.
module grayscale_erode_dilate_window_unit import gedw_pkg::*; #(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o,
  output logic                  row_end_o,
  output logic                  frame_end_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int WW = (CW + 1 > DIM_W) ? CW + 2 : DIM_W + 1;
  localparam int SW = $clog2(MAX_WINDOW);

  // Configuration registers
  logic              erode_q;
  logic [RAD_W-1:0]  radius_q;
  logic [MASK_W-1:0] mask_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erode_q  <= 1'b0;
      radius_q <= RAD_W'(1);
      mask_q   <= '1;
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ERODE:  erode_q  <= cfg_data_i[0];
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_MASK:   mask_q   <= cfg_data_i[MASK_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived geometry
  logic [RAD_W-1:0]  rad_eff;
  logic [RAD_W:0]    two_rad;
  logic [WW-1:0]     w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [MASK_W-1:0] eff_mask;

  always_comb begin
    rad_eff = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
    two_rad = {rad_eff, 1'b0};
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (WW'(width_q) > WW'(MAX_LINE)) begin
      w_eff = WW'(MAX_LINE);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(MAX_ROWS)) begin
      h_eff = DIM_W'(MAX_ROWS);
    end else begin
      h_eff = height_q;
    end
  end

  // Mask relocated to the bottom-right corner of the full window
  always_comb begin
    int base;
    base = MAX_WINDOW - 2 * int'(rad_eff) - 1;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if (k >= base && j >= base) begin
          eff_mask[k*MAX_WINDOW+j] = mask_q[(k-base)*MAX_WINDOW+(j-base)];
        end else begin
          eff_mask[k*MAX_WINDOW+j] = 1'b0;
        end
      end
    end
  end

  // Pipeline advance: everything moves unless a result is stuck
  logic adv;
  logic in_acc;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && adv;

  // Raster position counters; here_q tracks the row modulo the window
  logic [CW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [SW-1:0]    here_q;
  logic [CW-1:0]    col_eff;
  logic             last_col;
  logic             last_row;
  logic             emit;

  always_comb begin
    col_eff  = (col_q > CW'(MAX_LINE - 1)) ? CW'(MAX_LINE - 1) : col_q;
    last_col = (WW'(col_eff) + WW'(1)) >= w_eff;
    last_row = (DIM_W'(row_q) + DIM_W'(1)) >= h_eff;
    emit     = (col_eff >= CW'(two_rad)) && (row_q >= ROW_W'(two_rad));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      here_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        if (last_row) begin
          row_q  <= '0;
          here_q <= '0;
        end else begin
          row_q  <= row_q + ROW_W'(1);
          here_q <= (here_q == SW'(MAX_WINDOW - 1)) ? '0 : here_q + SW'(1);
        end
      end else begin
        col_q <= col_eff + CW'(1);
      end
    end
  end

  // Line stores, one per row slot
  logic [PIXEL_BITS-1:0] rd_data [MAX_WINDOW];

  for (genvar m = 0; m < MAX_WINDOW; m++) begin : g_slot
    gedw_line_store #(
      .DEPTH  (MAX_LINE),
      .DATA_W (PIXEL_BITS)
    ) u_store (
      .clk_i   (clk_i),
      .we_i    (in_acc && (here_q == SW'(m))),
      .re_i    (in_acc),
      .addr_i  (col_eff),
      .wdata_i (pixel_in_i),
      .rdata_o (rd_data[m])
    );
  end

  // Stage 1: pixel and flags alongside the line-store read
  logic                  s1_valid_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [SW-1:0]         s1_here_q;
  logic [2:0]            s1_flags_q;   // emit, row end, frame end
  logic [2:0]            s2_flags_q;
  logic [2:0]            s3_flags_q;
  logic                  s2_valid_q;
  logic                  s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q   <= pixel_in_i;
      s1_here_q  <= here_q;
      s1_flags_q <= {emit, last_col, last_col && last_row};
      s2_flags_q <= s1_flags_q;
      s3_flags_q <= s2_flags_q;
    end
  end

  // New window column: older rows from the stores, newest pixel at the bottom
  logic [PIXEL_BITS-1:0] new_col [MAX_WINDOW];

  always_comb begin
    logic [SW:0] sel;
    for (int k = 0; k < MAX_WINDOW - 1; k++) begin
      sel = {1'b0, s1_here_q} + (SW + 1)'(k + 1);
      if (sel >= (SW + 1)'(MAX_WINDOW)) begin
        sel = sel - (SW + 1)'(MAX_WINDOW);
      end
      new_col[k] = rd_data[sel[SW-1:0]];
    end
    new_col[MAX_WINDOW-1] = s1_pix_q;
  end

  // Row of window cells, column 0 oldest
  cell_ctrl_t            cell_ctrl;
  logic [PIXEL_BITS-1:0] cell_col  [MAX_WINDOW+1][MAX_WINDOW];
  logic [PIXEL_BITS-1:0] cell_part [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] cell_mask [MAX_WINDOW];

  assign cell_ctrl.shift = adv && s1_valid_q;
  assign cell_ctrl.adv   = adv;
  assign cell_ctrl.erode = erode_q;
  assign cell_col[MAX_WINDOW] = new_col;

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_mask
      assign cell_mask[j][k] = eff_mask[k*MAX_WINDOW+j];
    end

    gedw_cell #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .col_i  (cell_col[j+1]),
      .mask_i (cell_mask[j]),
      .col_o  (cell_col[j]),
      .part_o (cell_part[j])
    );
  end

  // Combine the column results
  logic [PIXEL_BITS-1:0] best_d;

  always_comb begin
    best_d = erode_q ? '1 : '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (erode_q ? (cell_part[j] < best_d) : (cell_part[j] > best_d)) begin
        best_d = cell_part[j];
      end
    end
  end

  // Output register
  logic                  out_valid_q;
  logic [PIXEL_BITS-1:0] pixel_out_q;
  logic                  row_end_q;
  logic                  frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q && s3_flags_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixel_out_q <= best_d;
      row_end_q   <= s3_flags_q[1];
      frame_end_q <= s3_flags_q[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

`ifndef ASSERT_OFF
  // The last result of a frame also closes a row
  a_frame_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame_end without row_end");

  // Row slot pointer restarts with the row counter
  a_slot_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q == '0) |-> (here_q == '0))
    else $error("row slot out of step with row counter");

  // Slot pointer stays inside the window
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    here_q < SW'(MAX_WINDOW))
    else $error("row slot beyond window");

  // A result appears only from a valid emitting stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s3_valid_q && s3_flags_q[2]))
    else $error("result without source transaction");
`endif

endmodule

// ----- rtl/gedw_line_store.sv -----
module gedw_line_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // One row slot: single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gedw_cell.sv -----
module gedw_cell import gedw_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [PIXEL_BITS-1:0] col_i [MAX_WINDOW],
  input  logic [MAX_WINDOW-1:0] mask_i,
  output logic [PIXEL_BITS-1:0] col_o [MAX_WINDOW],
  output logic [PIXEL_BITS-1:0] part_o
);

  logic [PIXEL_BITS-1:0] col_q [MAX_WINDOW];
  logic [PIXEL_BITS-1:0] part_d;
  logic [PIXEL_BITS-1:0] part_q;

  // Masked max/min down this window column
  always_comb begin
    part_d = ctrl_i.erode ? '1 : '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (mask_i[k] && (ctrl_i.erode ? (col_q[k] < part_d) : (col_q[k] > part_d))) begin
        part_d = col_q[k];
      end
    end
  end

  // Window column shifts toward the left neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        col_q[k] <= '0;
      end
    end else if (ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  // Column result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      part_q <= part_d;
    end
  end

  assign col_o  = col_q;
  assign part_o = part_q;

endmodule

// ----- tb/sv/tb_grayscale_erode_dilate_window_unit.sv -----
`timescale 1ns / 1ps

module tb_grayscale_erode_dilate_window_unit import gedw_pkg::*; ();

  localparam int PX_W          = 8;
  localparam int LINE_MAX      = 1024;
  localparam int SETTLE_CYCLES = 8;      // pipe is 4 deep, allow twice that
  localparam int QUIET_LIMIT   = 4000;   // cycles with no transaction at all
  localparam int RANDOM_PIXELS = 200;
  localparam int REPORT_CAP    = 200;

  localparam logic [PX_W-1:0]       PX_ZERO   = '0;
  localparam logic [PX_W-1:0]       PX_FULL   = '1;
  localparam logic [MASK_W-1:0]     MASK_ALL  = '1;
  localparam logic [MASK_W-1:0]     MASK_3X3  = 25'h0001CE7;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_SPARE = CFG_IDX_W'(CFG_HEIGHT) + 1'b1;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_TOP   = '1;

  typedef struct packed {
    logic [PX_W-1:0] pixel;
    logic            row_end;
    logic            frame_end;
  } win_result_t;

  typedef enum int {FILL_RANDOM, FILL_BAND, FILL_EXTREME, FILL_ZERO, FILL_ONES} fill_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // DUT ports
  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PX_W-1:0]       pixel_in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PX_W-1:0]       pixel_out_o;
  logic                  row_end_o;
  logic                  frame_end_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the filter: line memory, window, raster position, registers
  logic [PX_W-1:0]   line_mem [MAX_WINDOW][LINE_MAX];
  logic [PX_W-1:0]   win_px   [MAX_WINDOW][MAX_WINDOW];
  logic [ROW_W-1:0]  col_pos;
  logic [ROW_W-1:0]  row_pos;
  logic              cfg_erode;
  logic [RAD_W-1:0]  cfg_radius;
  logic [MASK_W-1:0] cfg_mask;
  logic [DIM_W-1:0]  cfg_width;
  logic [DIM_W-1:0]  cfg_height;

  win_result_t due_results_q[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int pixels_sent   = 0;
  int results_seen  = 0;
  int frames_done   = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  grayscale_erode_dilate_window_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Width and height: zero means one, anything past the limit saturates
  function automatic int dim_limit(input logic [DIM_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // Advance the shadow filter by one pixel; queue the window result if one is due
  task automatic predict_window_result(input logic [PX_W-1:0] pix);
    int w, h, col, row, here, rad, side, base;
    logic [PX_W-1:0] best, v;
    bit last_col, last_row;
    win_result_t r;
    w    = dim_limit(cfg_width, LINE_MAX);
    h    = dim_limit(cfg_height, MAX_ROWS);
    col  = int'(col_pos);
    row  = int'(row_pos);
    here = row % MAX_WINDOW;

    // shift left, pull the column from the line memory, newest pixel bottom right
    for (int k = 0; k < MAX_WINDOW; k++)
      for (int j = 0; j < MAX_WINDOW - 1; j++)
        win_px[k][j] = win_px[k][j+1];
    for (int k = 0; k < MAX_WINDOW - 1; k++)
      win_px[k][MAX_WINDOW-1] = line_mem[(here + k + 1) % MAX_WINDOW][col];
    win_px[MAX_WINDOW-1][MAX_WINDOW-1] = pix;
    line_mem[here][col] = pix;

    rad  = (int'(cfg_radius) > MAX_RADIUS) ? MAX_RADIUS : int'(cfg_radius);
    side = 2 * rad + 1;
    base = MAX_WINDOW - side;
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);

    // masked max (dilate) or min (erode) once the window sits inside the frame
    if (col >= 2 * rad && row >= 2 * rad) begin
      best = cfg_erode ? PX_FULL : PX_ZERO;
      for (int i = 0; i < side; i++)
        for (int j = 0; j < side; j++)
          if (cfg_mask[i*MAX_WINDOW + j]) begin
            v = win_px[base+i][base+j];
            if (cfg_erode ? (v < best) : (v > best)) best = v;
          end
      r.pixel     = best;
      r.row_end   = last_col;
      r.frame_end = last_col && last_row;
      due_results_q.push_back(r);
    end

    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : ROW_W'(row + 1);
    end else begin
      col_pos = ROW_W'(col + 1);
    end
  endtask

  // Register write; bits above the register width carry junk that must be dropped
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    int bits;
    logic [CFG_DATA_W-1:0] keep, data;
    case (idx)
      CFG_ERODE:             bits = 1;
      CFG_RADIUS:            bits = RAD_W;
      CFG_WIDTH, CFG_HEIGHT: bits = DIM_W;
      default:               bits = CFG_DATA_W;
    endcase
    keep = CFG_DATA_W'((64'd1 << bits) - 1);
    data = (value & keep) | (CFG_DATA_W'($urandom) & ~keep);
    case (idx)
      CFG_ERODE:  cfg_erode  = data[0];
      CFG_RADIUS: cfg_radius = data[RAD_W-1:0];
      CFG_MASK:   cfg_mask   = data[MASK_W-1:0];
      CFG_WIDTH:  cfg_width  = data[DIM_W-1:0];
      CFG_HEIGHT: cfg_height = data[DIM_W-1:0];
      default: ;
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait until every expected result is out, then let the pipe settle
  task automatic quiesce(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_results_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic load_config(input logic erode, input logic [RAD_W-1:0] rad,
                             input logic [MASK_W-1:0] mask,
                             input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height);
    quiesce(SETTLE_CYCLES);
    write_reg(CFG_ERODE, CFG_DATA_W'(erode));
    write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
    write_reg(CFG_MASK, CFG_DATA_W'(mask));
    write_reg(CFG_WIDTH, CFG_DATA_W'(width));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(height));
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 55; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 55; end
      default:       begin send_idle_pct = 24; stall_pct = 24; end
    endcase
  endtask

  function automatic logic [PX_W-1:0] pick_pixel(input fill_e style);
    case (style)
      FILL_BAND:    return PX_W'($urandom_range(126, 129));  // straddles the msb flip
      FILL_EXTREME: return $urandom_range(1) ? PX_FULL : PX_ZERO;
      FILL_ZERO:    return PX_ZERO;
      FILL_ONES:    return PX_FULL;
      default:      return PX_W'($urandom);
    endcase
  endfunction

  // One pixel transaction; valid holds until taken, then an optional idle gap
  task automatic send_pixel(input logic [PX_W-1:0] value);
    pixel_in_i <= value;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_window_result(value);
    pixels_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_pixels(input int count, input fill_e style);
    for (int n = 0; n < count; n++) send_pixel(pick_pixel(style));
  endtask

  // Send until the raster position is back at the frame origin; optional drain midway
  task automatic send_frame(input fill_e style, input int pause_at);
    int n;
    n = 0;
    do begin
      send_pixel(pick_pixel(style));
      n++;
      if (n == pause_at) quiesce(0);
    end while (col_pos != '0 || row_pos != '0);
    frames_done++;
  endtask

  // Power-up radius, mask and mode on a small frame, then shrink it mid-frame
  // so the counters wrap early
  task automatic test_reset_defaults;
    set_idle(IDLE_NONE);
    write_reg(CFG_WIDTH, CFG_DATA_W'(6));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(5));
    send_pixels(16, FILL_RANDOM);
    quiesce(SETTLE_CYCLES);
    write_reg(CFG_HEIGHT, CFG_DATA_W'(2));
    write_reg(CFG_WIDTH, CFG_DATA_W'(1));
    send_frame(FILL_RANDOM, -1);
  endtask

  // Walk a single mask bit over every window position for the small radii;
  // the full window takes the diagonal, random masks cover the rest
  task automatic test_mask_positions;
    int side, step, i, j;
    set_idle(IDLE_BOTH);
    for (int rad = 0; rad <= MAX_RADIUS; rad++) begin
      side = 2 * rad + 1;
      step = (rad == MAX_RADIUS) ? side + 1 : 1;
      for (int p = 0; p < side * side; p += step) begin
        i = p / side;
        j = p % side;
        load_config(logic'((i + j) & 1), RAD_W'(rad), MASK_W'(1) << (i*MAX_WINDOW + j),
                    DIM_W'(side), DIM_W'(side));
        send_frame(FILL_RANDOM, -1);
      end
    end
  endtask

  task automatic test_special_cases;
    set_idle(IDLE_SENDER);
    // empty mask gives the start value in both modes
    load_config(1'b0, 2'd1, '0, 11'd4, 11'd4);
    send_frame(FILL_RANDOM, -1);
    load_config(1'b1, 2'd1, '0, 11'd4, 11'd4);
    send_frame(FILL_RANDOM, -1);
    // mask bits outside a 3x3 window do not count
    load_config(1'b0, 2'd1, ~MASK_3X3, 11'd5, 11'd4);
    send_frame(FILL_RANDOM, -1);
    load_config(1'b1, 2'd1, ~MASK_3X3, 11'd5, 11'd4);
    send_frame(FILL_RANDOM, -1);
    // radius 3 behaves as 2
    load_config(1'b1, 2'd3, MASK_W'($urandom), 11'd6, 11'd6);
    send_frame(FILL_RANDOM, -1);
    load_config(1'b0, 2'd3, MASK_ALL, 11'd7, 11'd5);
    send_frame(FILL_BAND, -1);
    // zero width and height act as one: a 1x1 frame per pixel
    set_idle(IDLE_RECEIVER);
    load_config(1'b0, 2'd0, MASK_ALL, 11'd0, 11'd0);
    for (int n = 0; n < 3; n++) send_frame(FILL_RANDOM, -1);
    load_config(1'b1, 2'd0, MASK_ALL, 11'd0, 11'd0);
    send_frame(FILL_RANDOM, -1);
    // frames too narrow or too short for the window: nothing comes out
    load_config(1'b0, 2'd2, MASK_ALL, 11'd4, 11'd9);
    send_frame(FILL_RANDOM, -1);
    load_config(1'b1, 2'd1, MASK_ALL, 11'd7, 11'd2);
    send_frame(FILL_RANDOM, -1);
    // unused register indexes leave the setup alone
    load_config(1'b0, 2'd1, MASK_ALL, 11'd4, 11'd3);
    write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_IDX_TOP, CFG_DATA_W'($urandom));
    send_frame(FILL_RANDOM, -1);
    // pixel extremes in both modes
    set_idle(IDLE_NONE);
    load_config(1'b0, 2'd1, MASK_ALL, 11'd5, 11'd4);
    send_frame(FILL_ZERO, -1);
    send_frame(FILL_EXTREME, -1);
    load_config(1'b1, 2'd1, MASK_ALL, 11'd5, 11'd4);
    send_frame(FILL_ONES, -1);
    send_frame(FILL_EXTREME, -1);
  endtask

  task automatic test_geometry_extremes;
    set_idle(IDLE_RECEIVER);
    // width past the limit saturates to the full line
    load_config(1'b0, 2'd0, MASK_ALL, 11'd2047, 11'd1);
    send_frame(FILL_RANDOM, -1);
    // shrink width mid-row: column beyond the new end closes the row
    set_idle(IDLE_BOTH);
    load_config(1'b0, 2'd1, MASK_ALL, 11'd8, 11'd6);
    send_pixels(21, FILL_RANDOM);
    quiesce(SETTLE_CYCLES);
    write_reg(CFG_WIDTH, CFG_DATA_W'(3));
    send_frame(FILL_RANDOM, -1);
    // shrink height mid-frame: current row becomes the last one
    load_config(1'b1, 2'd1, MASK_ALL, 11'd4, 11'd9);
    send_pixels(21, FILL_RANDOM);
    quiesce(SETTLE_CYCLES);
    write_reg(CFG_HEIGHT, CFG_DATA_W'(3));
    send_frame(FILL_RANDOM, -1);
  endtask

  // Random setups, a few frames each, all idle modes in turn
  task automatic test_random_traffic;
    int first_px, group, npix;
    logic [MASK_W-1:0] mask;
    logic [DIM_W-1:0]  width;
    fill_e             style;
    first_px = pixels_sent;
    group    = 0;
    while (pixels_sent - first_px < RANDOM_PIXELS) begin
      set_idle(idle_mode_e'(group % 4));
      case ($urandom_range(3))
        0:       mask = MASK_ALL;
        1:       mask = MASK_W'($urandom);
        2:       mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
        default: mask = MASK_W'($urandom & $urandom & $urandom);
      endcase
      case ($urandom_range(9))
        0:       width = DIM_W'($urandom_range(13, 40));
        1:       width = '0;
        default: width = DIM_W'($urandom_range(1, 12));
      endcase
      load_config(logic'($urandom_range(1)), RAD_W'($urandom_range(3)), mask, width,
                  DIM_W'($urandom_range(0, 8)));
      npix = dim_limit(cfg_width, LINE_MAX) * dim_limit(cfg_height, MAX_ROWS);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        case ($urandom_range(9))
          6, 7:    style = FILL_BAND;
          8:       style = FILL_EXTREME;
          default: style = FILL_RANDOM;
        endcase
        send_frame(style, ($urandom_range(4) == 0) ? $urandom_range(1, npix) : -1);
      end
      group++;
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    win_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (due_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP)
          $display("%0t: unexpected result pixel %0d row_end %0b frame_end %0b",
                   $time, pixel_out_o, row_end_o, frame_end_o);
      end else begin
        want = due_results_q.pop_front();
        if (pixel_out_o !== want.pixel) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t: pixel_out expected %0d got %0d", $time, want.pixel, pixel_out_o);
        end
        if (row_end_o !== want.row_end) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t: row_end expected %0b got %0b", $time, want.row_end, row_end_o);
        end
        if (frame_end_o !== want.frame_end) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end, frame_end_o);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    pixel_in_i  <= '0;
    out_ready_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_ERODE;
    cfg_data_i  <= '0;

    // shadow state after reset
    for (int k = 0; k < MAX_WINDOW; k++) begin
      for (int c = 0; c < LINE_MAX; c++) line_mem[k][c] = '0;
      for (int j = 0; j < MAX_WINDOW; j++) win_px[k][j] = '0;
    end
    col_pos    = '0;
    row_pos    = '0;
    cfg_erode  = 1'b0;
    cfg_radius = RAD_W'(1);
    cfg_mask   = MASK_ALL;
    cfg_width  = DIM_W'(640);
    cfg_height = DIM_W'(480);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_mask_positions();
    test_special_cases();
    test_geometry_extremes();
    test_random_traffic();

    quiesce(2 * SETTLE_CYCLES);
    if (due_results_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, due_results_q.size());
    end

    $display("summary: %0d pixels over %0d frames, %0d results checked, %0d register writes",
             pixels_sent, frames_done, results_seen, cfg_writes);
    $display("summary: dilate and erode, radius 0 to 3, mask walk, border sizes, mid-frame shrink");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gedw_pkg.sv
rtl/gedw_line_store.sv
rtl/gedw_cell.sv
rtl/grayscale_erode_dilate_window_unit.sv
tb/sv/tb_grayscale_erode_dilate_window_unit.sv
